// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

   localparam int unsigned W = 32;               // entry width
   localparam int unsigned F = 16;               // fraction bits
   localparam int unsigned PROD_W = 2 * W;       // two-entry product
   localparam int unsigned ADJ_W = 2 * W + 1;    // cofactor, exact
   localparam int unsigned PART_W = 2 * W + 1;   // partial product of determinant
   localparam int unsigned DET_W = 3 * W + 3;    // determinant, exact
   localparam int unsigned R_W = DET_W + W + 2 * F + 4;   // divider working width

   localparam int unsigned COF_LAT = 5;          // cofactor/determinant stages
   localparam int unsigned LANE_LAT = W + 2;     // range check, W steps, saturation
   localparam int unsigned TOTAL_LAT = COF_LAT + LANE_LAT;

   // operand indexes (row*3+col) for adj[k] = m[a]*m[b] - m[c]*m[d]
   localparam int unsigned COF_IDX [9][4] = '{
      '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
      '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
      '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
   };

   typedef struct packed {
      logic [R_W-1:0] x;      // 2*(|adj| << 2F) + |det|
      logic [R_W-1:0] y;      // 2*|det|
      logic           neg;    // result sign
      logic           zero;   // determinant is zero
   } lane_in_type;

   typedef struct packed {
      logic [W-1:0] value;
      logic         zero;
   } lane_out_type;

endpackage

// ===== rtl/mi3_cofactor.sv =====
module mi3_cofactor (
   input  logic                      clock,
   input  logic signed [mi3_pkg::W-1:0] m_in [9],
   output mi3_pkg::lane_in_type      lane_out [9]
);

   localparam int unsigned W = mi3_pkg::W;

   logic signed [mi3_pkg::PROD_W-1:0] p0_ff [9];
   logic signed [mi3_pkg::PROD_W-1:0] p1_ff [9];
   logic signed [W-1:0] row1_ff [3];
   logic signed [W-1:0] row2_ff [3];
   logic signed [mi3_pkg::ADJ_W-1:0] adj2_ff [9];
   logic signed [mi3_pkg::ADJ_W-1:0] adj3_ff [9];
   logic signed [mi3_pkg::ADJ_W-1:0] adj4_ff [9];
   logic signed [mi3_pkg::PART_W-1:0] lo_ff [3];
   logic signed [mi3_pkg::PART_W-1:0] hi_ff [3];
   logic signed [mi3_pkg::DET_W-1:0] det_ff;
   logic signed [mi3_pkg::DET_W-1:0] det_in;
   logic [mi3_pkg::DET_W-1:0] det_abs;
   mi3_pkg::lane_in_type lane_ff [9];

   // stage 1: the eighteen two-entry products
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         p0_ff[k] <= m_in[mi3_pkg::COF_IDX[k][0]] * m_in[mi3_pkg::COF_IDX[k][1]];
         p1_ff[k] <= m_in[mi3_pkg::COF_IDX[k][2]] * m_in[mi3_pkg::COF_IDX[k][3]];
      end
      for (int j = 0; j < 3; j++) begin
         row1_ff[j] <= m_in[j];
      end
   end

   // stage 2: cofactors
   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         adj2_ff[k] <= mi3_pkg::ADJ_W'(p0_ff[k]) - mi3_pkg::ADJ_W'(p1_ff[k]);
      end
      row2_ff <= row1_ff;
   end

   // stage 3: row 0 times first adjugate column, split into low and high halves
   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         lo_ff[j] <= row2_ff[j] * $signed({1'b0, adj2_ff[3 * j][W-1:0]});
         hi_ff[j] <= row2_ff[j] * $signed(adj2_ff[3 * j][mi3_pkg::ADJ_W-1:W]);
      end
      adj3_ff <= adj2_ff;
   end

   // stage 4: determinant
   always_comb begin
      det_in = '0;
      for (int j = 0; j < 3; j++) begin
         det_in = det_in + (mi3_pkg::DET_W'(hi_ff[j]) <<< W) + mi3_pkg::DET_W'(lo_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      det_ff  <= det_in;
      adj4_ff <= adj3_ff;
   end

   // stage 5: magnitudes and divider operands
   assign det_abs = det_ff[mi3_pkg::DET_W-1] ? mi3_pkg::DET_W'(-det_ff)
                                              : mi3_pkg::DET_W'(det_ff);

   always_ff @(posedge clock) begin
      for (int k = 0; k < 9; k++) begin
         logic [mi3_pkg::ADJ_W-1:0] adj_abs;
         adj_abs = adj4_ff[k][mi3_pkg::ADJ_W-1] ? mi3_pkg::ADJ_W'(-adj4_ff[k])
                                                 : mi3_pkg::ADJ_W'(adj4_ff[k]);
         lane_ff[k].x    <= (mi3_pkg::R_W'(adj_abs) << (2 * mi3_pkg::F + 1))
                            + mi3_pkg::R_W'(det_abs);
         lane_ff[k].y    <= mi3_pkg::R_W'(det_abs) << 1;
         lane_ff[k].neg  <= adj4_ff[k][mi3_pkg::ADJ_W-1] ^ det_ff[mi3_pkg::DET_W-1];
         lane_ff[k].zero <= (det_ff == '0);
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== rtl/mi3_divider.sv =====
module mi3_divider (
   input  logic                  clock,
   input  mi3_pkg::lane_in_type  lane_in,
   output mi3_pkg::lane_out_type lane_out
);

   localparam int unsigned W = mi3_pkg::W;
   localparam int unsigned R_W = mi3_pkg::R_W;

   logic [R_W-1:0] rem_ff [W+1];
   logic [R_W-1:0] y_ff [W+1];
   logic [W-1:0]   q_ff [W+1];
   logic           ovf_ff [W+1];
   logic           neg_ff [W+1];
   logic           zero_ff [W+1];
   mi3_pkg::lane_out_type out_ff;

   // range check: quotient of 2^W or more saturates unless the determinant is zero
   always_ff @(posedge clock) begin
      rem_ff[0]  <= lane_in.x;
      y_ff[0]    <= lane_in.y;
      q_ff[0]    <= '0;
      ovf_ff[0]  <= lane_in.x >= (lane_in.y << W);
      neg_ff[0]  <= lane_in.neg;
      zero_ff[0] <= lane_in.zero;
   end

   // one restoring step per stage, most significant quotient bit first
   for (genvar s = 0; s < W; s++) begin : g_step
      localparam int unsigned BIT = W - 1 - s;
      logic [R_W-1:0] trial;
      assign trial = y_ff[s] << BIT;
      always_ff @(posedge clock) begin
         if (rem_ff[s] >= trial) begin
            rem_ff[s+1] <= rem_ff[s] - trial;
            q_ff[s+1]   <= q_ff[s] | (W'(1) << BIT);
         end else begin
            rem_ff[s+1] <= rem_ff[s];
            q_ff[s+1]   <= q_ff[s];
         end
         y_ff[s+1]    <= y_ff[s];
         ovf_ff[s+1]  <= ovf_ff[s];
         neg_ff[s+1]  <= neg_ff[s];
         zero_ff[s+1] <= zero_ff[s];
      end
   end

   // saturate, apply sign, force zero for a singular matrix
   always_ff @(posedge clock) begin
      logic [W-1:0] q;
      logic [W-1:0] lim;
      q   = q_ff[W];
      lim = W'(1) << (W - 1);
      out_ff.zero <= zero_ff[W];
      if (zero_ff[W]) begin
         out_ff.value <= '0;
      end else if (neg_ff[W]) begin
         out_ff.value <= (ovf_ff[W] || q > lim) ? lim : W'(-q);
      end else begin
         out_ff.value <= (ovf_ff[W] || q[W-1]) ? ~lim : q;
      end
   end

   assign lane_out = out_ff;

endmodule

// ===== rtl/matrix_inverse_3x3_top.sv =====
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------
// request   | start / busy       | req_m00 .. req_m22, signed Q16.16
// response  | rsp_valid (strobe) | rsp_inv00 .. rsp_inv22, rsp_singular
//
// One transaction enters every clock cycle; busy stays low.
// Pipeline: products, cofactors, determinant and divider operands, a range check,
// 32 restoring division steps (one quotient bit each, nine lanes) and saturation.
// Reset clears only the valid pipeline; data stages need no reset.
// The receiver cannot stall, so the pipeline never holds.
module matrix_inverse_3x3_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [mi3_pkg::W-1:0] req_m00,
   input  logic signed [mi3_pkg::W-1:0] req_m01,
   input  logic signed [mi3_pkg::W-1:0] req_m02,
   input  logic signed [mi3_pkg::W-1:0] req_m10,
   input  logic signed [mi3_pkg::W-1:0] req_m11,
   input  logic signed [mi3_pkg::W-1:0] req_m12,
   input  logic signed [mi3_pkg::W-1:0] req_m20,
   input  logic signed [mi3_pkg::W-1:0] req_m21,
   input  logic signed [mi3_pkg::W-1:0] req_m22,
   output logic                         rsp_valid,
   output logic signed [mi3_pkg::W-1:0] rsp_inv00,
   output logic signed [mi3_pkg::W-1:0] rsp_inv01,
   output logic signed [mi3_pkg::W-1:0] rsp_inv02,
   output logic signed [mi3_pkg::W-1:0] rsp_inv10,
   output logic signed [mi3_pkg::W-1:0] rsp_inv11,
   output logic signed [mi3_pkg::W-1:0] rsp_inv12,
   output logic signed [mi3_pkg::W-1:0] rsp_inv20,
   output logic signed [mi3_pkg::W-1:0] rsp_inv21,
   output logic signed [mi3_pkg::W-1:0] rsp_inv22,
   output logic                         rsp_singular
);

   logic signed [mi3_pkg::W-1:0] m [9];
   mi3_pkg::lane_in_type  lane_in [9];
   mi3_pkg::lane_out_type lane_out [9];
   logic [mi3_pkg::TOTAL_LAT-1:0] valid_ff;
   logic accept;

   // the pipeline never stalls, so a transaction is taken on any start
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign m = '{req_m00, req_m01, req_m02, req_m10, req_m11, req_m12,
                req_m20, req_m21, req_m22};

   // products, cofactors, determinant and divider operands
   mi3_cofactor u_cofactor (
      .clock    (clock),
      .m_in     (m),
      .lane_out (lane_in)
   );

   // one divider lane per inverse entry; adjugate k lands at inverse k
   for (genvar k = 0; k < 9; k++) begin : g_lane
      mi3_divider u_divider (
         .clock    (clock),
         .lane_in  (lane_in[k]),
         .lane_out (lane_out[k])
      );
   end

   // advance valid alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[mi3_pkg::TOTAL_LAT-2:0], accept};
      end
   end

   assign rsp_valid    = valid_ff[mi3_pkg::TOTAL_LAT-1];
   assign rsp_inv00    = lane_out[0].value;
   assign rsp_inv01    = lane_out[1].value;
   assign rsp_inv02    = lane_out[2].value;
   assign rsp_inv10    = lane_out[3].value;
   assign rsp_inv11    = lane_out[4].value;
   assign rsp_inv12    = lane_out[5].value;
   assign rsp_inv20    = lane_out[6].value;
   assign rsp_inv21    = lane_out[7].value;
   assign rsp_inv22    = lane_out[8].value;
   assign rsp_singular = lane_out[0].zero;

   // every response has a request exactly one latency before it
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, mi3_pkg::TOTAL_LAT))
      else $error("response without matching request");

   // a singular response carries all-zero entries
   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_inv00 == 0 && rsp_inv11 == 0 && rsp_inv22 == 0
         && rsp_inv01 == 0 && rsp_inv10 == 0 && rsp_inv02 == 0 && rsp_inv20 == 0
         && rsp_inv12 == 0 && rsp_inv21 == 0))
      else $error("singular response with nonzero entry");

   // lanes 0, 4 and 8 agree on the singular flag
   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (lane_out[0].zero == lane_out[4].zero
                     && lane_out[0].zero == lane_out[8].zero))
      else $error("divider lanes out of step");

endmodule
